// ----- hw/rtl/ffba_pkg.sv -----
// Shared constants and status codes of the first-fit block allocator.
package ffba_pkg;

  // Default geometry
  localparam int unsigned NumBlocksDef      = 32768;
  localparam int unsigned ReservedBlocksDef = 17;

  // Field widths
  localparam int unsigned IdxW    = 15;
  localparam int unsigned CntW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexLimit = 32768;

  // Usage map word geometry
  localparam int unsigned WordW = 64;
  localparam int unsigned BitW  = 6;

  // Request commands
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef logic [StatusW-1:0] status_t;

  localparam status_t StOk      = 2'd0;
  localparam status_t StNoSpace = 2'd1;
  localparam status_t StBadFree = 2'd2;

endpackage

// ----- hw/rtl/first_fit_block_allocator_core.sv -----
// Top level of the first-fit block allocator: map memory, sequencer, stream ports.
//
// Keeps one usage bit per block in a map memory of 64-bit words, with one read port
// and one write port, and a count of free blocks. Every request transaction yields
// one result transaction. After reset a clearing pass writes every map word once,
// one word per cycle, marking the reserved blocks and any tail bits past the managed
// range as used; no request is taken until it ends. An allocate scans the map from a
// first-fit hint (the lowest word that may hold a clear bit) upward, one word per
// cycle, set by the map read port. A free reads the block's word and clears its bit.
// An allocate on an empty pool or a free of an out-of-range or reserved block skips
// the map and goes straight to the result. A result waits in the output register
// for the consumer; the block takes one request at a time.
module first_fit_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS      = ffba_pkg::NumBlocksDef,
  parameter int unsigned RESERVED_BLOCKS = ffba_pkg::ReservedBlocksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [14:0] block_index, [15] zero
  input  logic        s_axis_tuser,  // [0] cmd
  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [14:0] granted_block, [30:15] free_count, [31] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int unsigned WordW    = ffba_pkg::WordW;
  localparam int unsigned BitW     = ffba_pkg::BitW;
  localparam int unsigned IdxW     = ffba_pkg::IdxW;
  localparam int unsigned CntW     = ffba_pkg::CntW;
  localparam int unsigned Managed  = (NUM_BLOCKS < ffba_pkg::IndexLimit) ?
                                     NUM_BLOCKS : ffba_pkg::IndexLimit;
  localparam int unsigned ResvEff  = (RESERVED_BLOCKS < Managed) ? RESERVED_BLOCKS : Managed;
  localparam int unsigned Depth    = (Managed + WordW - 1) / WordW;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TailBits = Managed - WordW * (Depth - 1);

  localparam logic [WordW-1:0] ResvMask = (WordW'(1) << ResvEff) - WordW'(1);
  localparam logic [WordW-1:0] TailMask = ~((WordW'(1) << TailBits) - WordW'(1));
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  // Sequencer states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StFree  = 3'd3;
  localparam logic [2:0] StPush  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [AddrW-1:0]       word_q, word_d;
  logic [AddrW-1:0]       hint_q, hint_d;
  logic [BitW-1:0]        bit_q, bit_d;
  logic [CntW-1:0]        free_q, free_d;
  ffba_pkg::status_t      res_status_q, res_status_d;
  logic [IdxW-1:0]        res_grant_q, res_grant_d;

  logic                   out_valid_q;
  ffba_pkg::status_t      out_status_q;
  logic [IdxW-1:0]        out_grant_q;
  logic [CntW-1:0]        out_count_q;
  logic                   out_load;

  // Map memory
  logic [WordW-1:0]       map_mem [Depth];
  logic [WordW-1:0]       rdata_q;
  logic [AddrW-1:0]       rd_addr;
  logic                   wr_en;
  logic [AddrW-1:0]       wr_addr;
  logic [WordW-1:0]       wr_data;

  logic                   scan_found;
  logic [BitW-1:0]        scan_bit;
  logic                   req_fire;
  logic [IdxW-1:0]        req_idx;
  logic [AddrW-1:0]       req_word;
  logic                   req_bad;
  logic [WordW-1:0]       bit_mask;

  assign req_fire = s_axis_tvalid && s_axis_tready;
  assign req_idx  = s_axis_tdata[IdxW-1:0];
  assign req_word = AddrW'(req_idx >> BitW);
  assign req_bad  = ({17'd0, req_idx} >= Managed) || ({17'd0, req_idx} < ResvEff);
  assign bit_mask = WordW'(1) << bit_q;

  ffba_scan u_scan (
    .word_i  (rdata_q),
    .found_o (scan_found),
    .bit_o   (scan_bit)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rdata_q <= map_mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    hint_d       = hint_q;
    bit_d        = bit_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    rd_addr      = word_q;
    wr_en        = 1'b0;
    wr_addr      = word_q;
    wr_data      = rdata_q;
    out_load     = 1'b0;

    unique case (state_q)
      StClear: begin
        // Write reserved and out-of-range bits as used, all others as free.
        wr_en   = 1'b1;
        wr_data = ((word_q == '0) ? ResvMask : '0) | ((word_q == LastAddr) ? TailMask : '0);
        word_d  = word_q + 1'b1;
        if (word_q == LastAddr) begin
          word_d  = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_fire) begin
          res_grant_d = '0;
          if (s_axis_tuser == ffba_pkg::CmdAlloc) begin
            if (free_q == '0) begin
              res_status_d = ffba_pkg::StNoSpace;
              state_d      = StPush;
            end else begin
              rd_addr = hint_q;
              word_d  = hint_q;
              state_d = StScan;
            end
          end else if (req_bad) begin
            res_status_d = ffba_pkg::StBadFree;
            state_d      = StPush;
          end else begin
            rd_addr = req_word;
            word_d  = req_word;
            bit_d   = req_idx[BitW-1:0];
            state_d = StFree;
          end
        end
      end
      StScan: begin
        if (scan_found) begin
          // Claim the lowest clear bit of this word.
          wr_en        = 1'b1;
          wr_data      = rdata_q | (WordW'(1) << scan_bit);
          free_d       = free_q - 1'b1;
          hint_d       = word_q;
          res_status_d = ffba_pkg::StOk;
          res_grant_d  = IdxW'({word_q, scan_bit});
          state_d      = StPush;
        end else if (word_q == LastAddr) begin
          res_status_d = ffba_pkg::StNoSpace;
          res_grant_d  = '0;
          state_d      = StPush;
        end else begin
          // Advance to the next word; its read is in flight this cycle.
          word_d  = word_q + 1'b1;
          rd_addr = word_q + 1'b1;
        end
      end
      StFree: begin
        if ((rdata_q & bit_mask) != '0) begin
          wr_en        = 1'b1;
          wr_data      = rdata_q & ~bit_mask;
          free_d       = free_q + 1'b1;
          res_status_d = ffba_pkg::StOk;
          if (word_q < hint_q) begin
            hint_d = word_q;
          end
        end else begin
          res_status_d = ffba_pkg::StBadFree;
        end
        state_d = StPush;
      end
      StPush: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      word_q  <= '0;
      hint_q  <= '0;
      bit_q   <= '0;
      free_q  <= CntW'(Managed - ResvEff);
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      hint_q  <= hint_d;
      bit_q   <= bit_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
  end

  // Output register: drop valid once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
      out_count_q  <= free_q;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_grant_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- hw/rtl/ffba_scan.sv -----
// Lowest-clear-bit finder for one usage map word.
module ffba_scan (
  input  logic [ffba_pkg::WordW-1:0] word_i,
  output logic                       found_o,
  output logic [ffba_pkg::BitW-1:0]  bit_o
);

  logic [ffba_pkg::WordW-1:0] free_bits;
  logic [ffba_pkg::WordW-1:0] half_mask;

  // Binary search: narrow to the half that holds the lowest clear bit.
  always_comb begin
    free_bits = ~word_i;
    half_mask = '0;
    bit_o     = '0;
    for (int lvl = ffba_pkg::BitW - 1; lvl >= 0; lvl--) begin
      half_mask = (ffba_pkg::WordW'(1) << (1 << lvl)) - ffba_pkg::WordW'(1);
      if ((free_bits & half_mask) == '0) begin
        bit_o[lvl] = 1'b1;
        free_bits  = free_bits >> (1 << lvl);
      end
    end
  end

  assign found_o = |(~word_i);

endmodule
